>>> src/rau_pkg.sv
`default_nettype none
package rau_pkg;

    localparam int OPW   = 32;
    localparam int WIDE  = 64;
    localparam int DENW  = 63;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    localparam logic [WIDE-1:0] MAG_MAX = {1'b0, {(WIDE-1){1'b1}}};

    typedef struct packed {
        logic           neg;
        logic [OPW-1:0] mag;
    } t_smag;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_MUL0, S_MUL1, S_MUL2, S_SUM, S_ZCHK,
        S_GCD, S_GCD_WAIT, S_QN, S_QN_WAIT, S_QD, S_QD_WAIT, S_DONE
    } t_state;

    typedef enum logic [1:0] {MS_P0, MS_P1, MS_D} t_mul_sel;
    typedef enum logic [1:0] {DS_GCD, DS_NUM, DS_DEN} t_div_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sum;
        logic     gcd_init;
        logic     gcd_step;
        logic     div_start;
        t_div_sel div_sel;
        logic     store_qn;
        logic     store_qd;
        logic     set_err;
        logic     set_zero;
    } t_cmd;

    typedef struct packed {
        logic in_err;
        logic n_zero;
        logic y_zero;
        logic div_done;
    } t_stat;

    function automatic t_smag operand(input logic [31:0] raw);
        t_smag          r;
        logic [OPW-1:0] v;
        v     = raw[OPW-1:0];
        r.neg = v[OPW-1];
        r.mag = v[OPW-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/rau_if.sv
`default_nettype none
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
    modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] res_num;
    logic [62:0] res_den;
    logic        err;
    modport source (output valid, res_num, res_den, err, input ready);
    modport sink   (input valid, res_num, res_den, err, output ready);
endinterface
`default_nettype wire

>>> src/rau_div.sv
`default_nettype none
module rau_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [rau_pkg::WIDE-1:0] i_dividend,
    input  wire logic [rau_pkg::WIDE-1:0] i_divisor,
    output logic [rau_pkg::WIDE-1:0]  o_quo,
    output logic [rau_pkg::WIDE-1:0]  o_rem,
    output logic                      o_done
);
    import rau_pkg::*;

    localparam int CW = $clog2(WIDE);

    logic [WIDE-1:0] r_rem, r_quo, r_dvs;
    logic [CW-1:0]   r_cnt;
    logic            r_busy, r_done;
    logic [WIDE:0]   trial, diff;

    always_comb begin
        trial = {r_rem, r_quo[WIDE-1]};
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDE - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[WIDE]) begin
                r_rem <= diff[WIDE-1:0];
                r_quo <= {r_quo[WIDE-2:0], 1'b1};
            end else begin
                r_rem <= trial[WIDE-1:0];
                r_quo <= {r_quo[WIDE-2:0], 1'b0};
            end
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_done = r_done;
endmodule
`default_nettype wire

>>> src/rau_dp.sv
`default_nettype none
module rau_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rau_pkg::t_cmd i_cmd,
    input  wire logic [1:0]    i_mode,
    input  wire logic [31:0]   i_a_num,
    input  wire logic [31:0]   i_a_den,
    input  wire logic [31:0]   i_b_num,
    input  wire logic [31:0]   i_b_den,
    output rau_pkg::t_stat     o_stat,
    output logic [63:0]        o_res_num,
    output logic [62:0]        o_res_den,
    output logic               o_err
);
    import rau_pkg::*;

    logic [1:0]      r_mode;
    t_smag           r_an, r_ad, r_bn, r_bd;
    logic [WIDE-1:0] r_p0, r_p1, r_d, r_n, r_x, r_y, r_nm;
    logic            r_p0_s, r_p1_s, r_d_s, r_n_s;
    logic [63:0]     r_res_num;
    logic [62:0]     r_res_den;
    logic            r_err;

    t_smag           mx, my;
    logic            m_s;
    logic [WIDE-1:0] prod;
    logic [WIDE-1:0] n_sum;
    logic            n_sum_s;
    logic [WIDE-1:0] dvd, dvs, quo, rem;
    logic            done;
    logic [WIDE-1:0] nm_sat;

    always_comb begin
        mx  = r_an;
        my  = r_bd;
        m_s = 1'b0;
        unique case (i_cmd.mul_sel)
            MS_P0: begin
                mx = r_an;
                my = (r_mode == MODE_MUL) ? r_bn : r_bd;
            end
            MS_P1: begin
                mx  = r_bn;
                my  = r_ad;
                m_s = (r_mode == MODE_SUB);
            end
            default: begin
                mx = r_ad;
                my = (r_mode == MODE_DIV) ? r_bn : r_bd;
            end
        endcase
        prod = {{(WIDE-OPW){1'b0}}, mx.mag} * {{(WIDE-OPW){1'b0}}, my.mag};
        m_s  = m_s ^ mx.neg ^ my.neg;
    end

    always_comb begin
        if (r_mode == MODE_MUL || r_mode == MODE_DIV) begin
            n_sum   = r_p0;
            n_sum_s = r_p0_s;
        end else if (r_p0_s == r_p1_s) begin
            n_sum   = r_p0 + r_p1;
            n_sum_s = r_p0_s;
        end else if (r_p0 >= r_p1) begin
            n_sum   = r_p0 - r_p1;
            n_sum_s = r_p0_s;
        end else begin
            n_sum   = r_p1 - r_p0;
            n_sum_s = r_p1_s;
        end
    end

    always_comb begin
        unique case (i_cmd.div_sel)
            DS_GCD: begin dvd = r_x; dvs = r_y; end
            DS_NUM: begin dvd = r_n; dvs = r_x; end
            default: begin dvd = r_d; dvs = r_x; end
        endcase
    end

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_quo      (quo),
        .o_rem      (rem),
        .o_done     (done)
    );

    assign nm_sat = (r_nm > MAG_MAX) ? MAG_MAX : r_nm;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_an   <= operand(i_a_num);
            r_ad   <= operand(i_a_den);
            r_bn   <= operand(i_b_num);
            r_bd   <= operand(i_b_den);
        end
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_sel)
                MS_P0:   begin r_p0 <= prod; r_p0_s <= m_s; end
                MS_P1:   begin r_p1 <= prod; r_p1_s <= m_s; end
                default: begin r_d  <= prod; r_d_s  <= m_s; end
            endcase
        end
        if (i_cmd.sum) begin
            r_n   <= n_sum;
            r_n_s <= n_sum_s;
        end
        if (i_cmd.gcd_init) begin
            r_x <= r_n;
            r_y <= r_d;
        end else if (i_cmd.gcd_step) begin
            r_x <= r_y;
            r_y <= rem;
        end
        if (i_cmd.store_qn) r_nm <= quo;
        if (i_cmd.store_qd) begin
            r_res_num <= (r_n_s ^ r_d_s) ? (~nm_sat + 1'b1) : nm_sat;
            r_res_den <= quo[DENW-1:0];
            r_err     <= 1'b0;
        end else if (i_cmd.set_err || i_cmd.set_zero) begin
            r_res_num <= '0;
            r_res_den <= 63'd1;
            r_err     <= i_cmd.set_err;
        end
    end

    always_comb begin
        o_stat.in_err   = (r_ad.mag == '0) || (r_bd.mag == '0) ||
                          ((r_mode == MODE_DIV) && (r_bn.mag == '0));
        o_stat.n_zero   = (r_n == '0);
        o_stat.y_zero   = (r_y == '0);
        o_stat.div_done = done;
    end

    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_err     = r_err;
endmodule
`default_nettype wire

>>> src/rau_ctrl.sv
`default_nettype none
module rau_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire rau_pkg::t_stat i_stat,
    output rau_pkg::t_cmd       o_cmd
);
    import rau_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.in_err) begin
                    o_cmd.set_err = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    n_state = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_P0;
                n_state       = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_P1;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_D;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_ZCHK;
            end
            S_ZCHK: begin
                if (i_stat.n_zero) begin
                    o_cmd.set_zero = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.gcd_init = 1'b1;
                    n_state        = S_GCD;
                end
            end
            S_GCD: begin
                if (i_stat.y_zero) begin
                    n_state = S_QN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DS_GCD;
                    n_state         = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.gcd_step = 1'b1;
                    n_state        = S_GCD;
                end
            end
            S_QN: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DS_NUM;
                n_state         = S_QN_WAIT;
            end
            S_QN_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.store_qn = 1'b1;
                    n_state        = S_QD;
                end
            end
            S_QD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DS_DEN;
                n_state         = S_QD_WAIT;
            end
            S_QD_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.store_qd = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> src/rational_arith_unit_top.sv
`default_nettype none
// A request with a zero denominator or divisor ends as an error after the check, and one with a
//   zero result ends after the sum; otherwise Euclid remainder steps run, then two final divisions.
// One request at a time; the next is taken no earlier than the cycle after the result leaves,
//   so each request goes through its bit-serial divisions before the next one starts.
// Reset: synchronous, active low; returns the controller to idle and stops the divider.
module rational_arith_unit_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rau_in_if.sink    i_req,
    rau_out_if.source o_rsp
);
    import rau_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rau_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_mode    (i_req.mode),
        .i_a_num   (i_req.a_num),
        .i_a_den   (i_req.a_den),
        .i_b_num   (i_req.b_num),
        .i_b_den   (i_req.b_den),
        .o_stat    (stat),
        .o_res_num (o_rsp.res_num),
        .o_res_den (o_rsp.res_den),
        .o_err     (o_rsp.err)
    );
endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import rau_pkg::*;

    typedef struct {
        logic [63:0] num;
        logic [62:0] den;
        logic        err;
    } t_frac_res;

    class frac_scoreboard;
        t_frac_res pending[$];
        int        mismatches;

        function void note_request(logic [1:0] mode, logic [31:0] an_raw, logic [31:0] ad_raw,
                                   logic [31:0] bn_raw, logic [31:0] bd_raw);
            t_frac_res    r;
            logic [63:0]  an, ad, bn, bd;
            logic [63:0]  nmag, dmag, x, y, t, nm, dm;
            logic         nneg, dneg;
            logic [63:0]  p1, p2;
            logic signed [64:0] s;
            an = 64'(signed'(an_raw));
            ad = 64'(signed'(ad_raw));
            bn = 64'(signed'(bn_raw));
            bd = 64'(signed'(bd_raw));
            r.num = '0;
            r.den = 63'd1;
            r.err = 1'b0;
            if (ad == 0 || bd == 0 || (mode == MODE_DIV && bn == 0)) begin
                r.err = 1'b1;
                pending.push_back(r);
                return;
            end
            if (mode == MODE_SUB)
                bn = -bn;
            // 32-bit operands: 64-bit two's complement products are exact
            case (mode)
                MODE_ADD, MODE_SUB: begin
                    p1 = an * bd;
                    p2 = bn * ad;
                    // sum may reach 2^63, so keep one extra bit for the sign
                    s    = 65'(signed'(p1)) + 65'(signed'(p2));
                    nneg = s[64];
                    nmag = nneg ? 64'(-s) : s[63:0];
                    dmag = ad * bd;
                end
                MODE_MUL: begin
                    nmag = an * bn;
                    nneg = nmag[63];
                    if (nneg) nmag = -nmag;
                    dmag = ad * bd;
                end
                default: begin
                    nmag = an * bd;
                    nneg = nmag[63];
                    if (nneg) nmag = -nmag;
                    dmag = ad * bn;
                end
            endcase
            dneg = dmag[63];
            if (nmag == 0) begin
                pending.push_back(r);
                return;
            end
            if (dneg) dmag = -dmag;
            x = nmag;
            y = dmag;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            nm = nmag / x;
            dm = dmag / x;
            if (nm > MAG_MAX) nm = MAG_MAX;
            r.num = (nneg != dneg) ? -nm : nm;
            r.den = dm[62:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic [63:0] num, logic [62:0] den, logic err);
            t_frac_res e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d/%0d err %0b",
                             $signed(num), den, err);
                return;
            end
            e = pending.pop_front();
            if (num !== e.num || den !== e.den || err !== e.err) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d/%0d err %0b, got %0d/%0d err %0b",
                             $signed(e.num), e.den, e.err, $signed(num), den, err);
            end
        endfunction
    endclass

    localparam int WATCHDOG = 100000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    rau_in_if  req_if();
    rau_out_if rsp_if();
    frac_scoreboard sb = new();
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int quiet_cycles = 0;

    rational_arith_unit_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        req_if.valid = 1'b0;
        req_if.mode  = MODE_ADD;
        req_if.a_num = '0;
        req_if.a_den = '0;
        req_if.b_num = '0;
        req_if.b_den = '0;
        rsp_if.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.mode, req_if.a_num, req_if.a_den,
                                req_if.b_num, req_if.b_den);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.res_num, rsp_if.res_den, rsp_if.err);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    always @(negedge i_clk)
        rsp_if.ready <= i_rst_n && ($urandom_range(99) >= snk_stall_pct);

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0001;
            2: return 32'h8000_0000;
            3: return '0;
            4: return 32'($signed($urandom_range(20)) - 10);
            5, 6: return 32'($urandom_range(1000));
            7: return -32'($urandom_range(1000));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(logic [1:0] mode, logic [31:0] an, logic [31:0] ad,
                                logic [31:0] bn, logic [31:0] bd);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode  <= mode;
        req_if.a_num <= an;
        req_if.a_den <= ad;
        req_if.b_num <= bn;
        req_if.b_den <= bd;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_request(2'($urandom_range(3)), pick_value(), pick_value(),
                         pick_value(), pick_value());
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_request(MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_request(MODE_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        send_request(MODE_MUL, -32'd4, 32'd6, 32'd3, -32'd8);
        send_request(MODE_DIV, 32'd5, 32'd7, -32'd10, 32'd21);
        send_request(MODE_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
        send_request(MODE_MUL, 32'd1, 32'd1, 32'd1, 32'd0);
        send_request(MODE_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
        send_request(MODE_MUL, 32'd0, -32'd9, 32'd3, 32'd5);
        send_request(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1);
        send_request(MODE_ADD, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        send_request(MODE_SUB, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(MODE_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000);
        send_request(MODE_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
        send_request(MODE_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(MODE_SUB, 32'd6, 32'd4, 32'd3, 32'd2);
        send_request(MODE_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_random(200);
        src_idle_pct = 60;
        send_random(150);
        src_idle_pct = 0;
        snk_stall_pct = 60;
        send_random(150);
        src_idle_pct = 20;
        snk_stall_pct = 20;
        send_random(150);
        req_if.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
src/rau_pkg.sv
src/rau_if.sv
src/rau_div.sv
src/rau_dp.sv
src/rau_ctrl.sv
src/rational_arith_unit_top.sv
tb/testbench.sv
